@@ sv/fss_pkg.sv @@
package fss_pkg;

  // Default number of bytes in the allocation table.
  localparam int TABLE_BYTES_DEF = 8192;

  // Fixed field widths.
  localparam int OP_W      = 2;
  localparam int TADDR_W   = 13;
  localparam int CLUSTER_W = 12;
  localparam int SECTOR_W  = 7;
  localparam int SPC_W     = 8;
  localparam int LBA_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = 22;

  // Cluster values at or above this mark end a chain.
  localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LBA = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_OPEN = 2'd1,
    OP_NEXT = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_RD_DONE,
    S_MUL,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tbl_wr;
    logic do_open;
    logic do_step;
    logic rd_sel_hi;
    logic cap_lo;
    logic chain_upd;
    logic mul_en;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ended;
    logic wrap;
    logic out_free;
  } sts_t;

endpackage

@@ sv/fss_ram.sv @@
module fss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/fss_ctrl.sv @@
module fss_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fss_pkg::OP_W-1:0]    in_opcode,
  input  fss_pkg::sts_t               sts,
  output fss_pkg::cmd_t               cmd
);
  import fss_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;
  op_t    op;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(in_opcode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD: begin
              cmd.tbl_wr = 1'b1;
            end
            OP_OPEN: begin
              cmd.do_open = 1'b1;
              state_nxt   = S_MUL;
            end
            OP_NEXT: begin
              if (sts.ended) begin
                state_nxt = S_MUL;
              end else begin
                cmd.do_step = 1'b1;
                state_nxt   = sts.wrap ? S_RD_LO : S_MUL;
              end
            end
            OP_RSVD: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RD_LO: begin
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_sel_hi = 1'b1;
        cmd.cap_lo    = 1'b1;
        state_nxt     = S_RD_DONE;
      end
      S_RD_DONE: begin
        cmd.chain_upd = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A table read always runs both byte fetches back to back.
  a_rd_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD_LO |=> state_r == S_RD_HI ##1 state_r == S_RD_DONE)
    else $error("table read sequence broken");

  // An accepted open always goes straight to the address multiply.
  a_open_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_OPEN) |=> state_r == S_MUL)
    else $error("open did not start address computation");

endmodule

@@ sv/fss_dp.sv @@
module fss_dp #(
  parameter int TABLE_BYTES = fss_pkg::TABLE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fss_pkg::cmd_t                     cmd,
  output fss_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [fss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fss_pkg::LBA_W-1:0]         cfg_wdata,
  input  logic [fss_pkg::TADDR_W-1:0]       in_table_address,
  input  logic [7:0]                        in_table_byte,
  input  logic [fss_pkg::CLUSTER_W-1:0]     in_first_cluster,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fss_pkg::LBA_W-1:0]         out_sector_lba,
  output logic                              out_end_of_chain
);
  import fss_pkg::*;

  localparam int AW    = $clog2(TABLE_BYTES);
  localparam int IDX_W = TADDR_W + 1;
  localparam logic [IDX_W-1:0] TB_LIMIT = IDX_W'(TABLE_BYTES);

  logic [SPC_W-1:0]     spc_r, spc_nxt;
  logic [LBA_W-1:0]     lba_r, lba_nxt;
  logic [CLUSTER_W-1:0] cluster_r, cluster_nxt;
  logic [SECTOR_W-1:0]  sector_r, sector_nxt;
  logic                 ended_r, ended_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           lo_r;
  logic                 oob_r;
  logic [PROD_W-1:0]    prod_r;
  logic [LBA_W-1:0]     out_lba_r;
  logic                 out_eoc_r;

  logic [SPC_W-1:0]     spc_eff;
  logic [SPC_W-1:0]     s_inc;
  logic [IDX_W-1:0]     triple;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_ok;
  logic [7:0]           ram_q;
  logic [7:0]           rd_byte;
  logic [15:0]          word;
  logic [CLUSTER_W-1:0] next_cl;
  logic signed [CLUSTER_W:0] cl_m2;
  logic signed [SPC_W:0]     spc_s;
  logic [LBA_W-1:0]     lba_sum;

  // Zero sectors per cluster acts as one, more than 128 as 128.
  always_comb begin
    if (spc_r == '0) begin
      spc_eff = SPC_W'(1);
    end else if (spc_r > SPC_W'(128)) begin
      spc_eff = SPC_W'(128);
    end else begin
      spc_eff = spc_r;
    end
  end

  assign s_inc = {1'b0, sector_r} + SPC_W'(1);

  // Byte index of the entry: cluster * 3 / 2.
  assign triple  = {2'b00, cluster_r} + {1'b0, cluster_r, 1'b0};
  assign idx     = {1'b0, triple[IDX_W-1:1]};
  assign rd_addr = cmd.rd_sel_hi ? idx + IDX_W'(1) : idx;
  assign wr_ok   = cmd.tbl_wr && ({1'b0, in_table_address} < TB_LIMIT);

  fss_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_table (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (in_table_address[AW-1:0]),
    .wdata (in_table_byte),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_q)
  );

  // Bytes beyond the table read as zero.
  assign rd_byte = oob_r ? 8'h00 : ram_q;
  assign word    = {rd_byte, lo_r};
  assign next_cl = cluster_r[0] ? word[15:4] : word[11:0];

  assign cl_m2   = $signed({1'b0, cluster_r}) - 13'sd2;
  assign spc_s   = $signed({1'b0, spc_eff});
  assign lba_sum = lba_r + {{(LBA_W-PROD_W){prod_r[PROD_W-1]}}, prod_r}
                 + {{(LBA_W-SECTOR_W){1'b0}}, sector_r};

  always_comb begin
    spc_nxt     = spc_r;
    lba_nxt     = lba_r;
    cluster_nxt = cluster_r;
    sector_nxt  = sector_r;
    ended_nxt   = ended_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPC: spc_nxt = cfg_wdata[SPC_W-1:0];
        CFG_LBA: lba_nxt = cfg_wdata;
      endcase
    end
    if (cmd.do_open) begin
      cluster_nxt = in_first_cluster;
      sector_nxt  = '0;
      ended_nxt   = (in_first_cluster >= END_MARK);
    end
    if (cmd.do_step) begin
      sector_nxt = sts.wrap ? '0 : s_inc[SECTOR_W-1:0];
    end
    if (cmd.chain_upd) begin
      cluster_nxt = next_cl;
      ended_nxt   = (next_cl >= END_MARK);
    end
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r       <= SPC_W'(1);
      lba_r       <= '0;
      cluster_r   <= '0;
      sector_r    <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      spc_r       <= spc_nxt;
      lba_r       <= lba_nxt;
      cluster_r   <= cluster_nxt;
      sector_r    <= sector_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oob_r <= (rd_addr >= TB_LIMIT);
    if (cmd.cap_lo) begin
      lo_r <= rd_byte;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(cl_m2) * PROD_W'(spc_s);
    end
    if (cmd.out_load) begin
      out_lba_r <= ended_r ? '0 : lba_sum;
      out_eoc_r <= ended_r;
    end
  end

  assign sts.ended    = ended_r;
  assign sts.wrap     = (s_inc >= spc_eff);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_sector_lba   = out_lba_r;
  assign out_end_of_chain = out_eoc_r;

  // The end flag is sticky until the next open.
  a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ended_r && !cmd.do_open) |=> ended_r)
    else $error("end of chain flag dropped without an open");

  // Following the chain to an end marker raises the end flag.
  a_chain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.chain_upd && next_cl >= END_MARK) |=> ended_r)
    else $error("end marker not flagged");

endmodule

@@ sv/fat12_sector_sequencer_top.sv @@
// FAT12 cluster chain walker.
// Input channel (in_valid / in_stall) carries one beat per command:
//   load table byte, open at a first cluster, or step to the next sector.
// Output channel (out_valid / out_stall) carries one beat per open or
//   next-sector command: the sector address and an end-of-chain flag.
//   Loads and the unused opcode produce no output beat.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes sectors per
//   cluster (index 0) and the data area start sector (index 1).
// Timing: loads can arrive every cycle while no other command is in flight. An open,
//   a next-sector that stays within its cluster, or a next-sector after the end
//   of the chain goes through the address multiply and then the output write. A
//   next-sector that crosses into a new cluster first reads two bytes through the
//   single table RAM read port, then does the address multiply and add.
// The block handles one command at a time; in_stall is high while a command
//   is in flight, and also while a finished result cannot yet be written
//   because the previous output beat is still stalled.
// Reset clears the walk state (cluster 0, sector 0, no end flag) and sets
//   sectors per cluster to 1 and the data start to 0. The table contents are
//   not cleared and must be loaded before use.
module fat12_sector_sequencer_top #(
  parameter int TABLE_BYTES = fss_pkg::TABLE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fss_pkg::LBA_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fss_pkg::OP_W-1:0]          in_opcode,
  input  logic [fss_pkg::TADDR_W-1:0]       in_table_address,
  input  logic [7:0]                        in_table_byte,
  input  logic [fss_pkg::CLUSTER_W-1:0]     in_first_cluster,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fss_pkg::LBA_W-1:0]         out_sector_lba,
  output logic                              out_end_of_chain
);
  import fss_pkg::*;

  // Commands and status between the sequencing controller and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller decodes each accepted beat and steps through the table
  // reads, the multiply and the output write.
  fss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the table RAM, the walk state, the configuration
  // registers and the output register.
  fss_dp #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_table_address (in_table_address),
    .in_table_byte    (in_table_byte),
    .in_first_cluster (in_first_cluster),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sector_lba   (out_sector_lba),
    .out_end_of_chain (out_end_of_chain)
  );

endmodule
